// File: sv/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types, command codes and slot tables for the I2C bit sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    localparam logic [2:0] MODE_TICK  = 3'd0;
    localparam logic [2:0] MODE_START = 3'd1;
    localparam logic [2:0] MODE_STOP  = 3'd2;
    localparam logic [2:0] MODE_WRITE = 3'd3;
    localparam logic [2:0] MODE_READ  = 3'd4;
    localparam logic [2:0] MODE_SACK  = 3'd5;
    localparam logic [2:0] MODE_RACK  = 3'd6;

    // active command code of zero means no command in progress
    localparam logic [2:0] CMD_IDLE = 3'd0;

    localparam logic [15:0] SLOT_TICKS_RESET = 16'd10;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] data_byte;
        logic       ack_bit;
        logic       sda_in;
    } i2cms_in_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       ack_seen;
        logic       rejected;
    } i2cms_out_t;

    typedef struct packed {
        logic [4:0]  action_idx;
        logic [15:0] slot_cnt;
        logic [2:0]  cmd;
        logic [7:0]  shift;
        logic        scl_drive;
        logic        sda_drive;
        logic        ack;
        logic [7:0]  last_read;
    } i2cms_state_t;

    typedef struct packed {
        logic done;
        logic rej;
    } i2cms_flags_t;

    function automatic logic [4:0] seq_length(input logic [2:0] cmd);
        logic [4:0] len;
        case (cmd)
            MODE_START: len = 5'd4;
            MODE_STOP:  len = 5'd3;
            MODE_WRITE: len = 5'd24;
            MODE_READ:  len = 5'd25;
            MODE_SACK:  len = 5'd4;
            MODE_RACK:  len = 5'd4;
            default:    len = 5'd0;
        endcase
        return len;
    endfunction

    // k / 3 for k below 32: (k * 11) >> 5 is exact over that range
    function automatic logic [3:0] div3(input logic [4:0] k);
        logic [8:0] prod;
        prod = {4'd0, k} * 9'd11;
        return prod[8:5];
    endfunction

endpackage

// File: sv/i2cms_step.sv
// ----------------------------------------------------------------------------
// i2cms_step
// Next-state logic for one transfer: tick counting, slot stepping and the
// slot action that drives SCL/SDA, samples SDA or assembles the read byte.
// ----------------------------------------------------------------------------
module i2cms_step (
    input  i2cms_pkg::i2cms_in_t    item,
    input  i2cms_pkg::i2cms_state_t cur,
    input  logic [15:0]             slot_ticks,
    output i2cms_pkg::i2cms_state_t nxt,
    output i2cms_pkg::i2cms_flags_t flags
);
    import i2cms_pkg::*;

    function automatic i2cms_state_t do_action(input i2cms_state_t s,
                                               input logic [4:0] k,
                                               input logic sda);
        i2cms_state_t o;
        logic [4:0]   kk;
        logic [3:0]   q;
        logic [4:0]   r;
        logic [2:0]   b;
        o  = s;
        kk = (s.cmd == MODE_READ) ? (k - 5'd1) : k;
        q  = div3(kk);
        r  = kk - 5'({q, 1'b0} + {1'b0, q});
        b  = q[2:0];
        case (s.cmd)
            MODE_START: begin
                case (k)
                    5'd0:    o.sda_drive = 1'b1;
                    5'd1:    o.scl_drive = 1'b1;
                    5'd2:    o.sda_drive = 1'b0;
                    default: o.scl_drive = 1'b0;
                endcase
            end
            MODE_STOP: begin
                case (k)
                    5'd0:    o.sda_drive = 1'b0;
                    5'd1:    o.scl_drive = 1'b1;
                    default: o.sda_drive = 1'b1;
                endcase
            end
            MODE_WRITE: begin
                case (r)
                    5'd0:    o.sda_drive = s.shift[3'd7 - b];
                    5'd1:    o.scl_drive = 1'b1;
                    default: o.scl_drive = 1'b0;
                endcase
            end
            MODE_READ: begin
                if (k == 5'd0)
                begin
                    o.sda_drive = 1'b1;
                end
                else
                begin
                    case (r)
                        5'd0:    o.scl_drive = 1'b1;
                        5'd1:    o.shift[3'd7 - b] = s.shift[3'd7 - b] | sda;
                        default: o.scl_drive = 1'b0;
                    endcase
                end
            end
            MODE_SACK: begin
                case (k)
                    5'd0:    o.scl_drive = 1'b0;
                    5'd1:    o.sda_drive = s.shift[0];
                    5'd2:    o.scl_drive = 1'b1;
                    default: o.scl_drive = 1'b0;
                endcase
            end
            MODE_RACK: begin
                case (k)
                    5'd0:    o.sda_drive = 1'b1;
                    5'd1:    o.scl_drive = 1'b1;
                    5'd2:    o.ack       = sda;
                    default: o.scl_drive = 1'b0;
                endcase
            end
            default: o = s;
        endcase
        return o;
    endfunction

    logic [15:0]  limit;
    logic [15:0]  cnt_inc;
    logic [4:0]   idx_inc;
    i2cms_state_t loaded;

    always_comb
    begin
        limit   = (slot_ticks == 16'd0) ? 16'd1 : slot_ticks;
        cnt_inc = cur.slot_cnt + 16'd1;
        idx_inc = cur.action_idx + 5'd1;

        loaded            = cur;
        loaded.cmd        = item.mode;
        loaded.action_idx = 5'd0;
        loaded.slot_cnt   = 16'd0;
        case (item.mode)
            MODE_WRITE: loaded.shift = item.data_byte;
            MODE_READ:  loaded.shift = 8'd0;
            MODE_SACK:  loaded.shift = {7'd0, item.ack_bit};
            default:    loaded.shift = cur.shift;
        endcase

        nxt        = cur;
        flags.done = 1'b0;
        flags.rej  = 1'b0;

        if (item.mode == MODE_TICK)
        begin
            if (cur.cmd != CMD_IDLE)
            begin
                nxt.slot_cnt = cnt_inc;
                // counter wrap also ends the slot
                if (cnt_inc >= limit || cnt_inc == 16'd0)
                begin
                    nxt.slot_cnt = 16'd0;
                    if (idx_inc >= seq_length(cur.cmd))
                    begin
                        if (cur.cmd == MODE_READ)
                            nxt.last_read = cur.shift;
                        flags.done     = 1'b1;
                        nxt.cmd        = CMD_IDLE;
                        nxt.action_idx = 5'd0;
                    end
                    else
                    begin
                        nxt            = do_action(cur, idx_inc, item.sda_in);
                        nxt.slot_cnt   = 16'd0;
                        nxt.action_idx = idx_inc;
                    end
                end
            end
        end
        else if (item.mode <= MODE_RACK)
        begin
            if (cur.cmd != CMD_IDLE)
                flags.rej = 1'b1;
            else
                nxt = do_action(loaded, 5'd0, item.sda_in);
        end
    end

endmodule

// File: sv/i2c_master_bit_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// I2C master bit-level sequencer: steps SCL/SDA through slot actions.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready channel of items. mode 0 is a tick from the time base;
//           modes 1..6 issue start, stop, write, read, send ack, receive ack.
//   out_* : valid/ready channel, exactly one result per input transfer,
//           carrying the line levels and status after that item.
//   cfg_wr_en/cfg_wr_data: slot_ticks, to be written only while idle; the block does not enforce this.
// Flow: an accepted item lands in the input register; its result is computed
//   from it and the state and is registered in the output register when that
//   register is empty or being read.
// Throughput: one item per clock while not stalled by out_ready; the state
//   update is one short pass of logic between the input and output registers.
// Stall: when out_ready is low the output register holds, the input register
//   fills and in_ready drops; nothing is lost or skipped.
// Reset: lines released high, idle, slot_ticks = 10, both stages empty.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  i2cms_pkg::i2cms_in_t   in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output i2cms_pkg::i2cms_out_t  out_data,
    input  logic                   cfg_wr_en,
    input  logic [15:0]            cfg_wr_data
);
    import i2cms_pkg::*;

    logic         in_valid_reg;
    i2cms_in_t    in_data_reg;
    logic         out_valid_reg;
    i2cms_out_t   out_data_reg;
    logic [15:0]  slot_ticks_reg;
    i2cms_state_t state_reg;
    i2cms_state_t state_next;
    i2cms_flags_t flags;
    i2cms_out_t   out_data_next;
    logic         advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    i2cms_step u_step (
        .item       (in_data_reg),
        .cur        (state_reg),
        .slot_ticks (slot_ticks_reg),
        .nxt        (state_next),
        .flags      (flags)
    );

    always_comb
    begin
        out_data_next.scl_level = state_next.scl_drive;
        out_data_next.sda_level = state_next.sda_drive;
        out_data_next.busy_res  = (state_next.cmd != CMD_IDLE);
        out_data_next.done_res  = flags.done;
        out_data_next.read_byte = state_next.last_read;
        out_data_next.ack_seen  = state_next.ack;
        out_data_next.rejected  = flags.rej;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            slot_ticks_reg <= SLOT_TICKS_RESET;
            state_reg      <= '{action_idx: 5'd0, slot_cnt: 16'd0, cmd: CMD_IDLE,
                                shift: 8'd0, scl_drive: 1'b1, sda_drive: 1'b1,
                                ack: 1'b0, last_read: 8'd0};
        end
        else
        begin
            if (cfg_wr_en)
                slot_ticks_reg <= cfg_wr_data;
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                state_reg <= state_next;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_data_reg <= in_data;
        if (advance)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
